FILE: hdl/packed_normal_decode_unit_assert.svh
// Assertion macros for the packed normal decode unit.
`ifndef PACKED_NORMAL_DECODE_UNIT_ASSERT_SVH
`define PACKED_NORMAL_DECODE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PND_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PND_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PND_ASSERT_IMPL(label, ante, cons, msg)
`define PND_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hdl/pnd_pkg.sv
package pnd_pkg;

  localparam int OUT_W       = 17;
  localparam int SQ_W        = 32;
  localparam int RAD_W       = 31;
  localparam int ROOT_BITS   = 16;
  localparam int DEC_STAGES  = 5;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_STEPS  = ROOT_BITS / SQRT_STAGES;

  localparam logic [RAD_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sh0FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 17'sh10000;

  // x/y components and z sign riding alongside the z computation
  typedef struct packed {
    logic                    zsign;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } pnd_side_t;

  // digit-by-digit square root state
  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } pnd_sq_t;

  function automatic pnd_sq_t sqrt_step(pnd_sq_t cur, logic [SQ_W-1:0] one_hot);
    pnd_sq_t     nxt;
    logic [SQ_W:0] trial;
    trial = {1'b0, cur.res} + {1'b0, one_hot};
    if ({1'b0, cur.rem} >= trial) begin
      nxt.rem = cur.rem - trial[SQ_W-1:0];
      nxt.res = (cur.res >> 1) + one_hot;
    end else begin
      nxt.rem = cur.rem;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

endpackage

FILE: hdl/pnd_decode.sv
module pnd_decode #(
  parameter int FRACTION_BITS = 15
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [15:0]       first_word,
  input  logic signed [15:0]       second_word,
  output logic                     out_valid,
  output pnd_pkg::pnd_side_t       out_side
);

  localparam int F    = FRACTION_BITS;
  localparam int LW   = (F < 16) ? F : 16;
  localparam int MAGW = F + 1;
  localparam int NW   = 2 * F + 17;
  localparam int MW   = F + 17;
  localparam int QW1  = MW - F;
  localparam int TW   = ((F > QW1) ? F : QW1) + 1;
  localparam int QW2  = TW - F;
  localparam int QW   = 18;
  localparam int OW   = pnd_pkg::OUT_W;

  localparam logic [MAGW-1:0] ONE  = MAGW'(1) << F;
  localparam logic [NW-1:0]   HALF = (NW'(1) << (2 * F - 1)) - (NW'(1) << (F - 1));
  localparam logic [F-1:0]    DIV  = {F{1'b1}};
  localparam logic [QW-1:0]   POS_LIM = QW'(65535);
  localparam logic [QW-1:0]   NEG_LIM = QW'(65536);

  logic [3:0]          vld;
  logic [3:0]          zs;
  logic [1:0]          neg1, neg2, neg3, neg4;
  logic [1:0]          neg_n;
  logic [MAGW-1:0]     mag1 [2];
  logic [MAGW-1:0]     mag_n [2];
  logic [MW-1:0]       m2 [2];
  logic [MW-1:0]       m_n [2];
  logic [QW1-1:0]      q1r [2];
  logic [QW1-1:0]      q1_n [2];
  logic [QW2-1:0]      q2r [2];
  logic [QW2-1:0]      q2_n [2];
  logic [TW-1:0]       t2r [2];
  logic [TW-1:0]       t2_n [2];
  logic [QW-1:0]       q4 [2];
  logic [QW-1:0]       q_n [2];
  logic signed [OW-1:0] val_n [2];

  // Component = round(mag * 2^15 * (2^F+1) / (2^F * (2^F-1))).
  // The 2^F is a shift; the 2^F-1 divide folds the high part onto the low part.
  always_comb begin
    logic [15:0]     w;
    logic [MAGW-1:0] lsb;
    logic [MAGW-1:0] twice;
    logic [NW-1:0]   prod;
    logic [NW-1:0]   num;
    logic [TW-1:0]   t1;
    logic [TW-1:0]   t3;
    logic [QW2-1:0]  q3;
    for (int l = 0; l < 2; l++) begin
      w        = (l == 0) ? first_word : second_word;
      lsb      = MAGW'(w[LW-1:0]);
      twice    = lsb << 1;
      neg_n[l] = twice < ONE;
      mag_n[l] = neg_n[l] ? ONE - twice : twice - ONE;

      prod   = (NW'(mag1[l]) << F) + NW'(mag1[l]);
      num    = (prod << 15) + HALF;
      m_n[l] = num[NW-1:F];

      t1      = TW'(m2[l][MW-1:F]) + TW'(m2[l][F-1:0]);
      q1_n[l] = m2[l][MW-1:F];
      q2_n[l] = t1[TW-1:F];
      t2_n[l] = TW'(t1[TW-1:F]) + TW'(t1[F-1:0]);

      q3     = t2r[l][TW-1:F];
      t3     = TW'(q3) + TW'(t2r[l][F-1:0]);
      q_n[l] = QW'(q1r[l]) + QW'(q2r[l]) + QW'(q3) + QW'(t3 >= TW'(DIV));

      if (neg4[l]) begin
        val_n[l] = (q4[l] > NEG_LIM) ? pnd_pkg::OUT_MIN : OW'(QW'(0) - q4[l]);
      end else begin
        val_n[l] = (q4[l] > POS_LIM) ? pnd_pkg::OUT_MAX : OW'(q4[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    zs   <= {zs[2:0], first_word[15]};
    neg1 <= neg_n;
    neg2 <= neg1;
    neg3 <= neg2;
    neg4 <= neg3;
    mag1 <= mag_n;
    m2   <= m_n;
    q1r  <= q1_n;
    q2r  <= q2_n;
    t2r  <= t2_n;
    q4   <= q_n;
    out_side.zsign <= zs[3];
    out_side.x     <= val_n[0];
    out_side.y     <= val_n[1];
  end

endmodule

FILE: hdl/pnd_sqrt.sv
module pnd_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  pnd_pkg::pnd_side_t             in_side,
  input  logic [pnd_pkg::RAD_W-1:0]      rad,
  output logic                           out_valid,
  output pnd_pkg::pnd_side_t             out_side,
  output pnd_pkg::pnd_sq_t               out_sq
);

  localparam int NS = pnd_pkg::SQRT_STAGES;
  localparam int NJ = pnd_pkg::SQRT_STEPS;
  localparam int SW = pnd_pkg::SQ_W;

  logic [NS-1:0]       vld;
  pnd_pkg::pnd_sq_t    st [NS];
  pnd_pkg::pnd_sq_t    st_n [NS];
  pnd_pkg::pnd_side_t  side_r [NS];

  // each stage resolves NJ root bits, highest first
  always_comb begin
    pnd_pkg::pnd_sq_t cur;
    cur.rem = SW'(rad);
    cur.res = '0;
    for (int s = 0; s < NS; s++) begin
      for (int j = 0; j < NJ; j++) begin
        cur = pnd_pkg::sqrt_step(cur,
                SW'(1) << (2 * (pnd_pkg::ROOT_BITS - 1 - (s * NJ + j))));
      end
      st_n[s] = cur;
      cur     = st[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st        <= st_n;
    side_r[0] <= in_side;
    for (int s = 1; s < NS; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  assign out_valid = vld[NS-1];
  assign out_side  = side_r[NS-1];
  assign out_sq    = st[NS-1];

endmodule

FILE: hdl/packed_normal_decode_unit.sv
// Packed normal decoder: takes one item (two packed words) whenever start is
// high, in every cycle if needed, and returns normal_x/y/z in order. done is
// high for one cycle with each result. The pipeline never stalls, so busy is
// high only while rst is asserted and the receiver must take each result in
// the cycle done is shown. The pipeline holds five decoder stages (fraction,
// scaling, two-stage constant-divide fold, saturation), one squaring stage,
// one radicand stage, four stages of square root (four root bits each) and
// the rounding/output register.
`include "packed_normal_decode_unit_assert.svh"

module packed_normal_decode_unit #(
  parameter int FRACTION_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] first_word,
  input  logic signed [15:0] second_word,
  output logic               done,
  output logic signed [16:0] normal_x,
  output logic signed [16:0] normal_y,
  output logic signed [16:0] normal_z
);

  localparam int LATENCY = pnd_pkg::DEC_STAGES + pnd_pkg::SQRT_STAGES + 3;
  localparam int RW      = pnd_pkg::RAD_W;
  localparam int OW      = pnd_pkg::OUT_W;

  logic               accept;
  logic               dec_valid;
  pnd_pkg::pnd_side_t dec_side;
  logic signed [33:0] xprod, yprod;

  logic               sq_valid;
  pnd_pkg::pnd_side_t sq_side;
  logic [33:0]        xsq, ysq;

  logic               rad_valid;
  pnd_pkg::pnd_side_t rad_side;
  logic [RW-1:0]      rad;
  logic [RW-1:0]      rad_next;
  logic signed [35:0] diff;

  logic               root_valid;
  pnd_pkg::pnd_side_t root_side;
  pnd_pkg::pnd_sq_t   root_sq;
  logic [OW-1:0]      z_mag;

  assign busy   = rst;
  assign accept = start & ~busy;

  pnd_decode #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .first_word (first_word),
    .second_word(second_word),
    .out_valid  (dec_valid),
    .out_side   (dec_side)
  );

  assign xprod = dec_side.x * dec_side.x;
  assign yprod = dec_side.y * dec_side.y;

  // radicand 2^30 - X^2 - Y^2, clamped to 0..2^30
  always_comb begin
    diff = $signed(36'(pnd_pkg::ONE_Q30)) - $signed(36'(xsq)) - $signed(36'(ysq));
    if (diff < 0) begin
      rad_next = '0;
    end else if (diff > $signed(36'(pnd_pkg::ONE_Q30))) begin
      rad_next = pnd_pkg::ONE_Q30;
    end else begin
      rad_next = diff[RW-1:0];
    end
  end

  pnd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rad_valid),
    .in_side  (rad_side),
    .rad      (rad),
    .out_valid(root_valid),
    .out_side (root_side),
    .out_sq   (root_sq)
  );

  // round to nearest: up when remainder exceeds root
  assign z_mag = (root_sq.rem > root_sq.res) ? OW'(root_sq.res[OW-1:0] + 1'b1)
                                             : root_sq.res[OW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      rad_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      sq_valid  <= dec_valid;
      rad_valid <= sq_valid;
      done      <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_side  <= dec_side;
    xsq      <= xprod;
    ysq      <= yprod;
    rad_side <= sq_side;
    rad      <= rad_next;
    normal_x <= root_side.x;
    normal_y <= root_side.y;
    normal_z <= root_side.zsign ? OW'(-z_mag) : z_mag;
  end

  `PND_ASSERT_IMPL(a_done_latency, done, $past(accept, LATENCY), "result without transaction")
  `PND_ASSERT_IMPL(a_z_sign, done && (normal_z < 0), $past(accept && first_word[15], LATENCY), "negative z from non-negative word")
  `PND_ASSERT_IMPL(a_z_range, done, (normal_z <= 32768) && (normal_z >= -32768), "z out of unit range")
  `PND_ASSERT_NEXT(a_rad_clamp, sq_valid && ((35'(xsq) + 35'(ysq)) > 35'(pnd_pkg::ONE_Q30)), rad == '0, "radicand not clamped")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC_BITS     = 15;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int RANDOM_ITEMS  = 600;
  localparam int SETTLE_CYCLES = 24;

  typedef logic signed [pnd_pkg::OUT_W-1:0] q15_t;

  typedef struct packed {
    q15_t x;
    q15_t y;
    q15_t z;
  } normal_t;

  // Expected normals in acceptance order, plus the decode math that fills them.
  class normal_ledger;
    normal_t     pending_q[$];
    int unsigned mismatches = 0;

    function longint clip_q15(longint v);
      if (v > 65535) return 65535;
      if (v < -65536) return -65536;
      return v;
    endfunction

    function longint decode_axis(logic [15:0] word);
      longint unsigned one, frac, twice, mag, num, den, q;
      longint          r;
      bit              neg;
      one   = 64'd1 << FRAC_BITS;
      frac  = {48'd0, word} & (one - 1);
      twice = frac << 1;
      neg   = twice < one;
      mag   = neg ? (one - twice) : (twice - one);
      num   = mag * (one + 1) * 64'd32768;
      den   = one * (one - 1);
      q     = (num + den / 2) / den;
      r     = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
      return clip_q15(neg ? -r : r);
    endfunction

    // digit-by-digit root, then round to nearest
    function longint unsigned rounded_root(longint unsigned d);
      longint unsigned rem, root, probe;
      rem   = d;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem  = rem - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      if (rem > root) root += 1;
      return root;
    endfunction

    function normal_t predict_normal(logic [15:0] fw, logic [15:0] sw);
      normal_t n;
      longint  xv, yv, rad, zv;
      xv  = decode_axis(fw);
      yv  = decode_axis(sw);
      rad = (64'sd1 << 30) - xv * xv - yv * yv;
      if (rad < 0) rad = 0;
      if (rad > (64'sd1 << 30)) rad = 64'sd1 << 30;
      zv = longint'(rounded_root(rad));
      if (fw[15]) zv = -zv;
      zv  = clip_q15(zv);
      n.x = xv[pnd_pkg::OUT_W-1:0];
      n.y = yv[pnd_pkg::OUT_W-1:0];
      n.z = zv[pnd_pkg::OUT_W-1:0];
      return n;
    endfunction

    function void note_words(logic [15:0] fw, logic [15:0] sw);
      pending_q.push_back(predict_normal(fw, sw));
    endfunction

    function void check_normal(normal_t got);
      normal_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected normal x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        return;
      end
      want = pending_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("normal mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                   want.x, want.y, want.z, got.x, got.y, got.z);
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [15:0] first_word = '0;
  logic signed [15:0] second_word = '0;
  logic               busy;
  logic               done;
  q15_t               normal_x;
  q15_t               normal_y;
  q15_t               normal_z;

  normal_ledger ledger = new();
  int           quiet_cycles = 0;
  bit           gaps_on = 1'b1;

  packed_normal_decode_unit #(.FRACTION_BITS(FRAC_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_word(first_word),
    .second_word(second_word),
    .done(done),
    .normal_x(normal_x),
    .normal_y(normal_y),
    .normal_z(normal_z)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (start && !busy) ledger.note_words(first_word, second_word);
    if (done) ledger.check_normal('{normal_x, normal_y, normal_z});
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_words(logic [15:0] fw, logic [15:0] sw);
    start       <= 1'b1;
    first_word  <= fw;
    second_word <= sw;
    do @(posedge clk); while (busy);
    while (gaps_on && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off until every outstanding normal has come back
  task automatic drain_normals();
    start <= 1'b0;
    do @(posedge clk); while (ledger.outstanding() != 0);
  endtask

  function automatic logic [15:0] random_words_pick();
    logic [14:0] frac;
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      // around the center, where z is large and the unit circle edge lies
      1: frac = 15'(16384 + $urandom_range(23170) - 11585);
      2: frac = $urandom_range(1) ? 15'($urandom_range(63)) : 15'(32704 + $urandom_range(63));
      default: frac = 15'(16384 + $urandom_range(255) - 128);
    endcase
    return {1'($urandom_range(1)), frac};
  endfunction

  logic [31:0] directed_pairs[] = '{
    32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'hFFFF_0000,
    32'h4000_4000, 32'hC000_4000, 32'hC000_C000, 32'h4000_7FFF,
    32'h8000_4000, 32'h0000_4000, 32'h3FFF_4001, 32'hBFFF_4000,
    32'h5A82_4000, 32'h2000_6000, 32'hA000_E000, 32'h7FFF_0000,
    32'h0001_FFFE, 32'h4001_C001, 32'h8001_7FFE, 32'h5555_AAAA
  };

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_pairs[i])
      send_words(directed_pairs[i][31:16], directed_pairs[i][15:0]);
    drain_normals();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 250 && n < 400);
      if (n == 300) drain_normals();
      send_words(random_words_pick(), random_words_pick());
    end

    drain_normals();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
